### src/integer_to_ascii_unit_defines.svh
// Assertion macros shared by the integer to ASCII unit.
`ifndef INTEGER_TO_ASCII_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every clock edge outside reset.
`define I2A_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("integer_to_ascii_unit: check failed");
// Checked at every clock edge, reset included.
`define I2A_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("integer_to_ascii_unit: reset check failed");
`else
`define I2A_ASSERT(label, prop)
`define I2A_ASSERT_RST(label, prop)
`endif

`endif

### src/i2a_pkg.sv
// Constants, types and helper functions of the integer to ASCII unit.
package i2a_pkg;

    localparam int I2A_WORD_BITS = 32;      // default width of the converted word
    localparam int VAL_BITS      = 32;      // width of the word field
    localparam int BCD_DIGITS    = 10;      // decimal digits of a 32-bit magnitude
    localparam int BCD_BITS      = 4 * BCD_DIGITS;
    localparam int DAB_STEP      = 4;       // binary bits consumed per stage
    localparam int DAB_STAGES    = VAL_BITS / DAB_STEP;
    localparam int STAGES        = DAB_STAGES + 2;
    localparam int POS_BITS      = $clog2(BCD_DIGITS);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef logic [BCD_BITS-1:0] t_digits;
    typedef logic [POS_BITS-1:0] t_pos;

    // ASCII code of one digit value, 0 to 15.
    function automatic logic [7:0] digit_char(input logic [3:0] nib);
        logic [7:0] code;
        if (nib < 4'd10) begin
            code = CH_ZERO + {4'd0, nib};
        end else begin
            code = CH_A + {4'd0, nib} - 8'd10;
        end
        return code;
    endfunction

    // Position of the most significant non-zero digit, zero if all are zero.
    function automatic t_pos top_digit(input t_digits digits);
        t_pos pos;
        pos = '0;
        for (int i = 1; i < BCD_DIGITS; i++) begin
            if (digits[4*i +: 4] != 4'd0) begin
                pos = POS_BITS'(i);
            end
        end
        return pos;
    endfunction

endpackage

### src/integer_to_ascii_unit.sv
// Integer to ASCII converter: pipelined decimal conversion and a character serialiser.
// An item (kind on tuser, word on tdata) becomes one to eleven ASCII characters, most
// significant first, one per item on the master side, with tlast on the final one. Kind 0
// reads the low WORD_BITS bits as a signed number and gives an optional minus sign and
// decimal digits; kind 1 gives lower-case hex digits; zero gives "0". The word runs
// through a ten-stage pipeline (input register, sign and magnitude, then eight
// double-dabble stages of four bits each). The single output serialiser sends one
// character per cycle while the master side accepts them; the pipeline keeps later
// items queued behind it and accepts a new item whenever a stage frees up.
`include "integer_to_ascii_unit_defines.svh"

module integer_to_ascii_unit #(
    parameter int WORD_BITS = i2a_pkg::I2A_WORD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] word
    input  logic        i_s_axis_tuser,   // [0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] char_code
    output logic        o_m_axis_tlast
);

    localparam int STAGES   = i2a_pkg::STAGES;
    localparam int VAL_BITS = i2a_pkg::VAL_BITS;
    localparam int MASK_W   = (WORD_BITS < VAL_BITS) ? WORD_BITS : VAL_BITS;
    localparam int SIGN_IDX = MASK_W - 1;
    localparam bit HAS_SIGN = (WORD_BITS <= VAL_BITS);
    localparam logic [VAL_BITS-1:0] WORD_MASK = {VAL_BITS{1'b1}} >> (VAL_BITS - MASK_W);

    // Pipeline stages.
    logic                      r_valid [STAGES];
    logic                      r_kind  [STAGES];
    logic                      r_neg   [STAGES];
    logic [VAL_BITS-1:0]       r_val   [STAGES];
    i2a_pkg::t_digits          r_bcd   [STAGES];
    logic                      n_valid [STAGES];
    logic                      n_kind  [STAGES];
    logic                      n_neg   [STAGES];
    logic [VAL_BITS-1:0]       n_val   [STAGES];
    i2a_pkg::t_digits          n_bcd   [STAGES];
    logic                      stg_ready [STAGES];

    // Serialiser and output register.
    logic             r_ser_valid, n_ser_valid;
    logic             r_ser_minus, n_ser_minus;
    i2a_pkg::t_digits r_ser_digits, n_ser_digits;
    i2a_pkg::t_pos    r_ser_pos, n_ser_pos;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_data, n_out_data;
    logic             r_out_last, n_out_last;

    logic ser_emit;
    logic ser_last;
    logic ser_free;

    assign ser_emit = r_ser_valid && (!r_out_valid || i_m_axis_tready);
    assign ser_last = !r_ser_minus && (r_ser_pos == '0);
    assign ser_free = !r_ser_valid || (ser_emit && ser_last);

    // A stage takes a new item when it is empty or its item moves on.
    always_comb begin
        stg_ready[STAGES-1] = !r_valid[STAGES-1] || ser_free;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stg_ready[k] = !r_valid[k] || stg_ready[k+1];
        end
    end

    assign o_s_axis_tready = stg_ready[0];

    always_comb begin
        logic [VAL_BITS-1:0]  masked;
        logic                 sign;
        logic [VAL_BITS-1:0]  t_val;
        i2a_pkg::t_digits     t_bcd;
        masked = r_val[0] & WORD_MASK;
        sign   = HAS_SIGN && !r_kind[0] && masked[SIGN_IDX];
        t_val  = '0;
        t_bcd  = '0;
        for (int k = 0; k < STAGES; k++) begin
            n_valid[k] = r_valid[k];
            n_kind[k]  = r_kind[k];
            n_neg[k]   = r_neg[k];
            n_val[k]   = r_val[k];
            n_bcd[k]   = r_bcd[k];
            if (stg_ready[k]) begin
                if (k == 0) begin
                    n_valid[k] = i_s_axis_tvalid;
                    n_kind[k]  = i_s_axis_tuser;
                    n_neg[k]   = 1'b0;
                    n_val[k]   = i_s_axis_tdata;
                    n_bcd[k]   = '0;
                end else if (k == 1) begin
                    n_valid[k] = r_valid[0];
                    n_kind[k]  = r_kind[0];
                    n_neg[k]   = sign;
                    n_val[k]   = sign ? ((~masked + 1'b1) & WORD_MASK) : masked;
                    n_bcd[k]   = '0;
                end else begin
                    t_val = r_val[k-1];
                    t_bcd = r_bcd[k-1];
                    // Four double-dabble steps; hex items pass through unchanged.
                    if (!r_kind[k-1]) begin
                        for (int b = 0; b < i2a_pkg::DAB_STEP; b++) begin
                            for (int d = 0; d < i2a_pkg::BCD_DIGITS; d++) begin
                                if (t_bcd[4*d +: 4] >= 4'd5) begin
                                    t_bcd[4*d +: 4] = t_bcd[4*d +: 4] + 4'd3;
                                end
                            end
                            t_bcd = {t_bcd[i2a_pkg::BCD_BITS-2:0], t_val[VAL_BITS-1]};
                            t_val = {t_val[VAL_BITS-2:0], 1'b0};
                        end
                    end
                    n_valid[k] = r_valid[k-1];
                    n_kind[k]  = r_kind[k-1];
                    n_neg[k]   = r_neg[k-1];
                    n_val[k]   = t_val;
                    n_bcd[k]   = t_bcd;
                end
            end
        end
    end

    always_comb begin
        i2a_pkg::t_digits load_digits;
        load_digits  = r_kind[STAGES-1] ?
                       {{(i2a_pkg::BCD_BITS - VAL_BITS){1'b0}}, r_val[STAGES-1]} :
                       r_bcd[STAGES-1];
        n_ser_valid  = r_ser_valid;
        n_ser_minus  = r_ser_minus;
        n_ser_digits = r_ser_digits;
        n_ser_pos    = r_ser_pos;
        if (ser_free) begin
            n_ser_valid  = r_valid[STAGES-1];
            n_ser_minus  = r_neg[STAGES-1];
            n_ser_digits = load_digits;
            n_ser_pos    = i2a_pkg::top_digit(load_digits);
        end else if (ser_emit) begin
            if (r_ser_minus) begin
                n_ser_minus = 1'b0;
            end else begin
                n_ser_pos = r_ser_pos - 1'b1;
            end
        end

        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        if (ser_emit) begin
            n_out_valid = 1'b1;
            n_out_data  = r_ser_minus ? i2a_pkg::CH_MINUS :
                          i2a_pkg::digit_char(r_ser_digits[4*r_ser_pos +: 4]);
            n_out_last  = ser_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_valid[k] <= 1'b0;
            end
            r_ser_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                r_valid[k] <= n_valid[k];
            end
            r_ser_valid <= n_ser_valid;
            r_out_valid <= n_out_valid;
        end
        for (int k = 0; k < STAGES; k++) begin
            r_kind[k] <= n_kind[k];
            r_neg[k]  <= n_neg[k];
            r_val[k]  <= n_val[k];
            r_bcd[k]  <= n_bcd[k];
        end
        r_ser_minus  <= n_ser_minus;
        r_ser_digits <= n_ser_digits;
        r_ser_pos    <= n_ser_pos;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    `I2A_ASSERT(a_last_follows_final_char, (ser_emit && ser_last) |=> (o_m_axis_tvalid && o_m_axis_tlast))
    `I2A_ASSERT(a_hex_never_negative, (r_valid[1] && r_kind[1]) |-> !r_neg[1])
    `I2A_ASSERT(a_pos_in_range, r_ser_valid |-> (r_ser_pos < i2a_pkg::POS_BITS'(i2a_pkg::BCD_DIGITS)))
    `I2A_ASSERT(a_minus_not_last, (ser_emit && r_ser_minus) |=> (o_m_axis_tvalid && !o_m_axis_tlast))
    `I2A_ASSERT_RST(a_reset_clears_output, !i_rst_n |=> !o_m_axis_tvalid)

endmodule
